FILE: rtl/esa_pkg.sv
// Package for the edit-script to alignment converter.
// Holds the configuration register indexes and their type; no dependencies.
package esa_pkg;

    localparam int CFG_IDX_W = 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_LEN_FIRST  = t_cfg_idx'(0);
    localparam t_cfg_idx REG_LEN_SECOND = t_cfg_idx'(1);

endpackage

FILE: rtl/esa_ifs.sv
// Valid/ready channel interfaces of the edit-script to alignment converter.
// Depends on esa_pkg for the configuration index type.
interface esa_op_if #(parameter int OP_W = 17);
    logic                   valid;
    logic                   ready;
    logic signed [OP_W-1:0] edit_op;

    modport source (output valid, output edit_op, input ready);
    modport sink   (input valid, input edit_op, output ready);
endinterface

interface esa_res_if #(parameter int POS_W = 17, parameter int CNT_W = 16);
    logic             valid;
    logic             ready;
    logic             pair_valid;
    logic [POS_W-1:0] pos_first;
    logic [POS_W-1:0] pos_second;
    logic             done_res;
    logic [POS_W-1:0] aligned_length;
    logic [CNT_W-1:0] pair_count;

    modport source (output valid, output pair_valid, output pos_first, output pos_second,
                    output done_res, output aligned_length, output pair_count,
                    input ready);
    modport sink   (input valid, input pair_valid, input pos_first, input pos_second,
                    input done_res, input aligned_length, input pair_count,
                    output ready);
endinterface

interface esa_cfg_if #(parameter int DATA_W = 16);
    logic              valid;
    logic              ready;
    esa_pkg::t_cfg_idx index;
    logic [DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/edit_script_to_alignment.sv
// Edit-script to alignment converter: turns signed edit-script beats into aligned pairs.
// Ops pass the input register, then the result register; one op per cycle while the result sink is ready.
// The position and count registers update once for each op that moves to the result register.
// An input register and a result register keep both sides moving under back-pressure.
// Synchronous active-low reset clears the pipeline and state and sets both lengths to one.
// Depends on esa_pkg and the channel interfaces in esa_ifs.sv.
module edit_script_to_alignment #(
    parameter int POS_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    esa_op_if.sink     i_op,
    esa_res_if.source  o_res,
    esa_cfg_if.sink    i_cfg
);

    localparam int POS_W = POS_BITS + 1;
    localparam int CNT_W = POS_BITS;

    function automatic logic [POS_W-1:0] f_sat_add(input logic [POS_W-1:0] a,
                                                   input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
    endfunction

    logic [CNT_W-1:0] r_len_first;
    logic [CNT_W-1:0] r_len_second;

    logic             r_in_valid;
    logic [POS_W-1:0] r_op;

    logic [POS_W-1:0] r_first;
    logic [POS_W-1:0] r_second;
    logic [CNT_W-1:0] r_pairs;
    logic [POS_W-1:0] r_length;

    logic             r_out_valid;
    logic             r_pair_valid;
    logic [POS_W-1:0] r_pos_first;
    logic [POS_W-1:0] r_pos_second;
    logic             r_done;
    logic [POS_W-1:0] r_aligned_length;
    logic [CNT_W-1:0] r_pair_count;

    logic [POS_W-1:0] n_first;
    logic [POS_W-1:0] n_second;
    logic [CNT_W-1:0] n_pairs;
    logic [POS_W-1:0] n_length;
    logic             n_pair_valid;
    logic [POS_W-1:0] n_pos_first;
    logic [POS_W-1:0] n_pos_second;
    logic             n_done;
    logic [POS_W-1:0] n_aligned_length;
    logic [CNT_W-1:0] n_pair_count;

    logic             advance;
    logic             in_beat;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_op.ready  = !r_in_valid || advance;
    assign in_beat     = i_op.valid && i_op.ready;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid          = r_out_valid;
    assign o_res.pair_valid     = r_pair_valid;
    assign o_res.pos_first      = r_pos_first;
    assign o_res.pos_second     = r_pos_second;
    assign o_res.done_res       = r_done;
    assign o_res.aligned_length = r_aligned_length;
    assign o_res.pair_count     = r_pair_count;

    always_comb begin
        logic             neg;
        logic [POS_W-1:0] mag;
        logic [POS_W-1:0] len_first_ext;
        logic [POS_W-1:0] len_second_ext;
        neg            = r_op[POS_W-1];
        mag            = neg ? (~r_op + POS_W'(1)) : r_op;
        len_first_ext  = {1'b0, r_len_first};
        len_second_ext = {1'b0, r_len_second};

        n_first      = r_first;
        n_second     = r_second;
        n_pairs      = r_pairs;
        n_length     = r_length;
        n_pair_valid = 1'b0;

        if (r_first == '0 && r_second == '0 && mag != '0) begin
            if (neg) begin
                n_first = f_sat_add(r_first, mag);
            end else begin
                n_second = f_sat_add(r_second, mag);
            end
        end else if (r_first >= len_first_ext || r_second >= len_second_ext) begin
            n_first  = len_first_ext;
            n_second = len_second_ext;
        end else if (mag == '0) begin
            n_first      = f_sat_add(r_first, POS_W'(1));
            n_second     = f_sat_add(r_second, POS_W'(1));
            n_length     = f_sat_add(r_length, POS_W'(1));
            n_pairs      = (r_pairs == {CNT_W{1'b1}}) ? r_pairs : r_pairs + CNT_W'(1);
            n_pair_valid = 1'b1;
        end else if (!neg) begin
            n_second = f_sat_add(r_second, mag);
            n_length = f_sat_add(r_length, mag);
        end else begin
            n_first  = f_sat_add(r_first, mag);
            n_length = f_sat_add(r_length, mag);
        end

        n_done           = n_first >= len_first_ext && n_second >= len_second_ext;
        n_pos_first      = n_pair_valid ? n_first : '0;
        n_pos_second     = n_pair_valid ? n_second : '0;
        n_aligned_length = n_done ? n_length : '0;
        n_pair_count     = n_done ? n_pairs : '0;

        if (n_done) begin
            n_first  = '0;
            n_second = '0;
            n_pairs  = '0;
            n_length = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_first  <= CNT_W'(1);
            r_len_second <= CNT_W'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                esa_pkg::REG_LEN_FIRST:  r_len_first  <= i_cfg.data;
                esa_pkg::REG_LEN_SECOND: r_len_second <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_first     <= '0;
            r_second    <= '0;
            r_pairs     <= '0;
            r_length    <= '0;
        end else begin
            if (in_beat) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_first     <= n_first;
                r_second    <= n_second;
                r_pairs     <= n_pairs;
                r_length    <= n_length;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_op <= i_op.edit_op;
        end
        if (advance) begin
            r_pair_valid     <= n_pair_valid;
            r_pos_first      <= n_pos_first;
            r_pos_second     <= n_pos_second;
            r_done           <= n_done;
            r_aligned_length <= n_aligned_length;
            r_pair_count     <= n_pair_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_pair_positions: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.pair_valid) |-> (o_res.pos_first != '0 && o_res.pos_second != '0))
        else $error("Aligned pair beat carries a zero position.");

    a_totals_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.done_res) |->
            (o_res.aligned_length == '0 && o_res.pair_count == '0))
        else $error("Totals are nonzero on a beat without done.");

    a_clear_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_done) |=>
            (r_first == '0 && r_second == '0 && r_pairs == '0 && r_length == '0))
        else $error("State was not cleared after a finished script.");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_op.ready |-> (r_in_valid && r_out_valid && !o_res.ready))
        else $error("Input stalled while the pipeline had room.");
`endif

endmodule

FILE: sim/tb_edit_script_to_alignment.sv
// Self-checking testbench for the edit-script to alignment converter.
// Drives a directed table and then random edit scripts, and checks every result beat.
// Depends on esa_pkg, the channel interfaces in esa_ifs.sv and the converter itself.
module tb_edit_script_to_alignment;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          POS_BITS       = 16;
    localparam int unsigned POS_MAX        = (32'd1 << (POS_BITS + 1)) - 1;
    localparam int unsigned CNT_MAX        = (32'd1 << POS_BITS) - 1;
    localparam int          NUM_DIRECTED   = 30;
    localparam int          NUM_PHASES     = 10;
    localparam int          PHASE_OPS      = 50;
    localparam int          LONG_HOLD      = 300;
    localparam int          DRAIN_PAD      = 3;
    localparam int          WATCHDOG_LIMIT = 3000;

    typedef logic signed [16:0] t_op;

    typedef struct packed {
        logic        pair;
        logic [16:0] pos_a;
        logic [16:0] pos_b;
        logic        done;
        logic [16:0] span;
        logic [15:0] pairs;
    } t_align_res;

    typedef enum logic [0:0] {ROW_OP, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        esa_pkg::t_cfg_idx idx;
        logic [15:0]       data;
        t_op               op;
        logic              typed;
        t_align_res        want;
    } t_row;

    localparam t_align_res RES_QUIET      = '0;
    localparam t_align_res RES_DONE_EMPTY = '{1'b0, 17'd0, 17'd0, 1'b1, 17'd0, 16'd0};

    t_row directed_tab [NUM_DIRECTED] = '{
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd0,      1'b1,
          '{1'b1, 17'd1, 17'd1, 1'b1, 17'd1, 16'd1}},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd1,      1'b1, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     -17'sd1,     1'b1, RES_DONE_EMPTY},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd65535,  1'b1, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     -17'sd65535, 1'b1, RES_DONE_EMPTY},
        '{ROW_CFG, esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd0,      1'b0, RES_QUIET},
        '{ROW_CFG, esa_pkg::REG_LEN_SECOND, 16'd0,     17'sd0,      1'b0, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd0,      1'b1, RES_DONE_EMPTY},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd5,      1'b1, RES_DONE_EMPTY},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     -17'sd3,     1'b1, RES_DONE_EMPTY},
        '{ROW_CFG, esa_pkg::REG_LEN_FIRST,  16'd65535, 17'sd0,      1'b0, RES_QUIET},
        '{ROW_CFG, esa_pkg::REG_LEN_SECOND, 16'd65535, 17'sd0,      1'b0, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd0,      1'b1,
          '{1'b1, 17'd1, 17'd1, 1'b0, 17'd0, 16'd0}},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd65533,  1'b0, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     -17'sd65533, 1'b0, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd65535,  1'b0, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     -17'sd1,     1'b1,
          '{1'b0, 17'd0, 17'd0, 1'b1, 17'd131071, 16'd1}},
        '{ROW_CFG, esa_pkg::REG_LEN_FIRST,  16'd2,     17'sd0,      1'b0, RES_QUIET},
        '{ROW_CFG, esa_pkg::REG_LEN_SECOND, 16'd2,     17'sd0,      1'b0, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd0,      1'b0, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd0,      1'b1,
          '{1'b1, 17'd2, 17'd2, 1'b1, 17'd2, 16'd2}},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     -17'sd7,     1'b1, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd3,      1'b1, RES_DONE_EMPTY},
        '{ROW_CFG, esa_pkg::REG_LEN_FIRST,  16'd3,     17'sd0,      1'b0, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd0,      1'b0, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd0,      1'b0, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd4,      1'b0, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd0,      1'b0, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     -17'sd9,     1'b0, RES_QUIET},
        '{ROW_OP,  esa_pkg::REG_LEN_FIRST,  16'd0,     17'sd0,      1'b0, RES_QUIET}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    esa_op_if  #(.OP_W(17))               op_ch ();
    esa_res_if #(.POS_W(17), .CNT_W(16))  res_ch ();
    esa_cfg_if #(.DATA_W(16))             cfg_ch ();

    edit_script_to_alignment #(.POS_BITS(POS_BITS)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    int unsigned seq_len_a  = 1;
    int unsigned seq_len_b  = 1;
    int unsigned pos_a      = 0;
    int unsigned pos_b      = 0;
    int unsigned pair_tally = 0;
    int unsigned span_len   = 0;

    t_align_res pending_align [$];
    t_op        op_script [$];
    int         errors    = 0;
    int         hold_reqs = 0;
    int         quiet     = 0;
    bit         src_gaps  = 1'b1;
    bit         sink_gaps = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned sat_sum(input int unsigned a, input int unsigned b,
                                            input int unsigned lim);
        int unsigned s;
        s = a + b;
        return (s > lim) ? lim : s;
    endfunction

    function automatic t_align_res predict_align(input t_op v);
        t_align_res  r;
        logic [16:0] raw;
        bit          neg;
        int unsigned mag;
        r   = '0;
        raw = v;
        neg = v[16];
        mag = neg ? (32'h2_0000 - raw) : raw;
        if (pos_a == 0 && pos_b == 0 && mag != 0) begin
            if (neg) pos_a = sat_sum(pos_a, mag, POS_MAX);
            else     pos_b = sat_sum(pos_b, mag, POS_MAX);
        end else if (pos_a >= seq_len_a || pos_b >= seq_len_b) begin
            pos_a = seq_len_a;
            pos_b = seq_len_b;
        end else if (mag == 0) begin
            pos_a      = sat_sum(pos_a, 1, POS_MAX);
            pos_b      = sat_sum(pos_b, 1, POS_MAX);
            r.pair     = 1'b1;
            r.pos_a    = pos_a[16:0];
            r.pos_b    = pos_b[16:0];
            pair_tally = sat_sum(pair_tally, 1, CNT_MAX);
            span_len   = sat_sum(span_len, 1, POS_MAX);
        end else if (!neg) begin
            pos_b    = sat_sum(pos_b, mag, POS_MAX);
            span_len = sat_sum(span_len, mag, POS_MAX);
        end else begin
            pos_a    = sat_sum(pos_a, mag, POS_MAX);
            span_len = sat_sum(span_len, mag, POS_MAX);
        end
        if (pos_a >= seq_len_a && pos_b >= seq_len_b) begin
            r.done     = 1'b1;
            r.span     = span_len[16:0];
            r.pairs    = pair_tally[15:0];
            pos_a      = 0;
            pos_b      = 0;
            pair_tally = 0;
            span_len   = 0;
        end
        return r;
    endfunction

    function automatic int gap_size(input int rem);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(1, rem);
        if (r < 8) return rem;
        return (rem + 20 > 65535) ? 65535 : rem + int'($urandom_range(1, 20));
    endfunction

    function automatic int unsigned pick_len();
        if ($urandom_range(0, 9) < 7) return $urandom_range(1, 12);
        return $urandom_range(1, 65535);
    endfunction

    // Mostly well-formed scripts for the given lengths, with an occasional stray op that
    // breaks the script and leaves the block mid-way into the next one.
    function automatic void build_script(input int unsigned l1, input int unsigned l2);
        int g1;
        int g2;
        int sz;
        int pick;
        bit go_on;
        g1    = 0;
        g2    = 0;
        go_on = 1'b1;
        if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 1) begin
                sz = gap_size(l1);
                g1 = sz;
                op_script.push_back(t_op'(-sz));
            end else begin
                sz = gap_size(l2);
                g2 = sz;
                op_script.push_back(t_op'(sz));
            end
        end
        while (go_on && !(g1 >= l1 && g2 >= l2)) begin
            pick = $urandom_range(0, 99);
            if (g1 >= l1 || g2 >= l2 || pick < 6) begin
                op_script.push_back(t_op'(int'($urandom_range(0, 131070)) - 65535));
                go_on = 1'b0;
            end else if (pick < 55) begin
                g1++;
                g2++;
                op_script.push_back(t_op'(0));
            end else if (pick < 78) begin
                sz = gap_size(l1 - g1);
                g1 += sz;
                op_script.push_back(t_op'(-sz));
            end else begin
                sz = gap_size(l2 - g2);
                g2 += sz;
                op_script.push_back(t_op'(sz));
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want_v);
        $display("tb_edit_script_to_alignment: mismatch on %s: got %0d, expected %0d at %0t",
                 what, got, want_v, $realtime);
        errors++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want_v);
        if (got != want_v) report_mismatch(name, got, want_v);
    endtask

    task automatic send_op(input t_op v, input bit typed, input t_align_res want);
        t_align_res got;
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            op_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        op_ch.valid   <= 1'b1;
        op_ch.edit_op <= v;
        @(posedge i_clk);
        while (!op_ch.ready) @(posedge i_clk);
        got = predict_align(v);
        pending_align.push_back(typed ? want : got);
        @(negedge i_clk);
    endtask

    task automatic drain();
        op_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_align.size() != 0);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    task automatic cfg_write(input esa_pkg::t_cfg_idx idx, input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == esa_pkg::REG_LEN_FIRST) seq_len_a = value;
        else                               seq_len_b = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : result_sink
        int stall_left;
        int holds_done;
        stall_left   = 0;
        holds_done   = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else if (holds_done != hold_reqs) begin
                holds_done++;
                res_ch.ready <= 1'b0;
                stall_left = LONG_HOLD - 1;
            end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 16);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_align_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_align.size() == 0) begin
                report_mismatch("result beat with nothing expected", 0, 0);
            end else begin
                want = pending_align.pop_front();
                check_field("pair_valid", res_ch.pair_valid, want.pair);
                check_field("pos_first", res_ch.pos_first, want.pos_a);
                check_field("pos_second", res_ch.pos_second, want.pos_b);
                check_field("done_res", res_ch.done_res, want.done);
                check_field("aligned_length", res_ch.aligned_length, want.span);
                check_field("pair_count", res_ch.pair_count, want.pairs);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb_edit_script_to_alignment: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned l1;
        int unsigned l2;
        int          sent;
        i_rst_n       = 1'b0;
        op_ch.valid   = 1'b0;
        op_ch.edit_op = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = esa_pkg::REG_LEN_FIRST;
        cfg_ch.data   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (directed_tab[i].kind == ROW_CFG) begin
                drain();
                cfg_write(directed_tab[i].idx, directed_tab[i].data);
            end else begin
                send_op(directed_tab[i].op, directed_tab[i].typed, directed_tab[i].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    l1 = 65535;
                    l2 = 65535;
                end
                1: begin
                    l1 = 1;
                    l2 = 1;
                end
                2: begin
                    l1 = 1;
                    l2 = 65535;
                end
                3: begin
                    l1 = 65535;
                    l2 = 7;
                end
                default: begin
                    l1 = pick_len();
                    l2 = pick_len();
                end
            endcase
            drain();
            src_gaps  = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            sink_gaps = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            cfg_write(esa_pkg::REG_LEN_FIRST, l1[15:0]);
            cfg_write(esa_pkg::REG_LEN_SECOND, l2[15:0]);
            sent = 0;
            while (sent < PHASE_OPS) begin
                build_script(l1, l2);
                while (op_script.size() != 0) begin
                    send_op(op_script.pop_front(), 1'b0, RES_QUIET);
                    sent++;
                    if (p == 3 && sent == 10) hold_reqs++;
                    if (p == 5 && sent == 20) drain();
                end
            end
        end

        op_ch.valid <= 1'b0;
        while (pending_align.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_align.size() != 0) begin
            report_mismatch("results still outstanding", 0, pending_align.size());
        end
        if (errors == 0) begin
            $display("tb_edit_script_to_alignment: PASS");
        end else begin
            $display("tb_edit_script_to_alignment: FAIL");
        end
        $finish;
    end

endmodule
